// ----- rtl/core/mahalanobis_distance_squared_defines.svh -----
// Assertion macros shared by the distance block.
// Each macro checks one implication on the rising clock edge and is
// switched off while the synchronous reset is held low.
`ifndef MAHALANOBIS_DISTANCE_SQUARED_DEFINES_SVH
`define MAHALANOBIS_DISTANCE_SQUARED_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mds: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MDS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mds: next-cycle check failed");

`endif

// ----- rtl/core/mds_pkg.sv -----
`timescale 1ns / 1ps

package mds_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_MEAN    = 2'd0;
    localparam logic [1:0] CMD_FACTOR  = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    // Field widths of one input transaction.
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int IN_TDATA_W = 40;

    // Field widths of one result transaction.
    localparam int DIST_W      = 63;
    localparam int OUT_TDATA_W = 64;

    // Datapath widths. The row sum is sized for the largest feature count (16):
    // a 65-bit product summed 16 times needs 69 bits.
    localparam int DIFF_W = 33;
    localparam int PROD_W = 65;
    localparam int SUM_W  = 69;
    localparam int MAG_W  = SUM_W - 16;
    localparam int LO_W   = 27;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int SQ_W   = 2 * MAG_W;

    // Largest representable distance.
    localparam logic [DIST_W-1:0] DIST_TOP = {DIST_W{1'b1}};

    // Depth of the queue between the front and back ends.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One classified operation handed from the front end to the back end.
    typedef struct packed {
        logic [CMD_W-1:0]   kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_op;

endpackage

// ----- rtl/core/mds_front.sv -----
`timescale 1ns / 1ps

module mds_front #(
    parameter int NFEAT = 8
) (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mds_pkg::CMD_W-1:0]   i_cmd,
    input  logic [mds_pkg::INDEX_W-1:0] i_index,
    input  logic [mds_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_q_full,
    output logic                        o_push,
    output mds_pkg::t_op                o_op
);
    import mds_pkg::*;

    localparam int NTRI = NFEAT * (NFEAT + 1) / 2;

    logic w_keep;

    // Decide whether an accepted transaction carries work for the back end.
    // Unused commands and writes beyond the tables are dropped here.
    always_comb begin
        unique case (i_cmd)
            CMD_MEAN:    w_keep = ({2'b00, i_index} < 8'(NFEAT));
            CMD_FACTOR:  w_keep = ({2'b00, i_index} < 8'(NTRI));
            CMD_FEATURE: w_keep = 1'b1;
            default:     w_keep = 1'b0;
        endcase
    end

    // Items are taken whenever the queue has room.
    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && o_ready && w_keep;
    assign o_op.kind   = i_cmd;
    assign o_op.index  = i_index;
    assign o_op.value  = i_value;

endmodule

// ----- rtl/core/mds_queue.sv -----
`timescale 1ns / 1ps

module mds_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mds_pkg::t_op i_op,
    output logic         o_full,
    output logic         o_valid,
    output mds_pkg::t_op o_op,
    input  logic         i_pop
);
    import mds_pkg::*;

    t_op               r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ----- rtl/core/mds_back.sv -----
`timescale 1ns / 1ps

module mds_back #(
    parameter int NFEAT = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  mds_pkg::t_op               i_q_op,
    output logic                       o_q_pop,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [mds_pkg::DIST_W-1:0] o_res_dist,
    output logic                       o_res_sat
);
    import mds_pkg::*;
    `include "mahalanobis_distance_squared_defines.svh"

    localparam int NTRI   = NFEAT * (NFEAT + 1) / 2;
    localparam int POS_W  = (NFEAT > 1) ? $clog2(NFEAT) : 1;
    localparam int ADDR_W = (NTRI > 1) ? $clog2(NTRI) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ABS   = 3'd3;
    localparam logic [2:0] ST_SQ_LL = 3'd4;
    localparam logic [2:0] ST_SQ_HL = 3'd5;
    localparam logic [2:0] ST_SQ_HH = 3'd6;
    localparam logic [2:0] ST_ACC   = 3'd7;

    // Control state.
    logic [2:0]        r_state;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_j;
    logic [ADDR_W-1:0] r_base;
    logic              r_v1;
    logic              r_v2;
    logic [DIST_W-1:0] r_acc;
    logic              r_sat;
    logic              r_out_valid;

    // Tables and datapath registers.
    logic [VALUE_W-1:0]       r_mean [NFEAT];
    logic [VALUE_W-1:0]       r_factor [NTRI];
    logic signed [DIFF_W-1:0] r_diff [NFEAT];
    logic [VALUE_W-1:0]       r_fdata;
    logic signed [DIFF_W-1:0] r_dj;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic [MAG_W-1:0]         r_mag;
    logic [SQ_W-1:0]          r_sq;
    logic [DIST_W-1:0]        r_out_dist;
    logic                     r_out_sat;

    logic                     w_pop;
    logic                     w_feature;
    logic                     w_last;
    logic                     w_out_free;
    logic                     w_emit;
    logic signed [DIFF_W-1:0] w_diff;
    logic [ADDR_W-1:0]        w_raddr;
    logic [MAG_W-1:0]         w_y;
    logic [LO_W-1:0]          w_lo;
    logic [HI_W-1:0]          w_hi;
    logic                     w_term_sat;
    logic [DIST_W-1:0]        w_term;
    logic [DIST_W:0]          w_total;
    logic                     w_total_ovf;
    logic [DIST_W-1:0]        w_acc_next;
    logic                     w_sat_next;

    assign w_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign w_feature  = w_pop && (i_q_op.kind == CMD_FEATURE);
    assign w_last     = (r_pos == POS_W'(NFEAT - 1));
    assign w_out_free = !r_out_valid || i_res_ready;
    assign w_emit     = (r_state == ST_ACC) && w_last && w_out_free;
    assign o_q_pop    = w_pop;

    // Difference of the new feature from its mean, exact in 33 bits.
    assign w_diff = $signed({i_q_op.value[VALUE_W-1], i_q_op.value})
                  - $signed({r_mean[r_pos][VALUE_W-1], r_mean[r_pos]});

    // Factor entry for column j of the current row.
    assign w_raddr = r_base + ADDR_W'(r_j);

    // Row sum truncated to Q37.16, and the halves of its magnitude.
    assign w_y  = r_sum[SUM_W-1:16];
    assign w_lo = r_mag[LO_W-1:0];
    assign w_hi = r_mag[MAG_W-1:LO_W];

    // Squared term in Q47.16 with saturation, then the saturating running sum.
    assign w_term_sat  = |r_sq[SQ_W-1:DIST_W+16];
    assign w_term      = w_term_sat ? DIST_TOP : r_sq[DIST_W+15:16];
    assign w_total     = {1'b0, r_acc} + {1'b0, w_term};
    assign w_total_ovf = w_total[DIST_W];
    assign w_acc_next  = w_total_ovf ? DIST_TOP : w_total[DIST_W-1:0];
    assign w_sat_next  = r_sat || w_term_sat || w_total_ovf;

    // Sequencer: one operation at a time from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_j         <= '0;
            r_base      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_MAC);
            r_v2 <= r_v1;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_feature) begin
                        r_j     <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (r_j == r_pos) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    // The final product is summed in this cycle.
                    if (!r_v1) begin
                        r_state <= ST_ABS;
                    end
                end
                ST_ABS:   r_state <= ST_SQ_LL;
                ST_SQ_LL: r_state <= ST_SQ_HL;
                ST_SQ_HL: r_state <= ST_SQ_HH;
                ST_SQ_HH: r_state <= ST_ACC;
                ST_ACC: begin
                    if (!w_last) begin
                        r_acc   <= w_acc_next;
                        r_sat   <= w_sat_next;
                        r_pos   <= r_pos + 1'b1;
                        r_base  <= r_base + ADDR_W'(r_pos) + 1'b1;
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_acc       <= '0;
                        r_sat       <= 1'b0;
                        r_pos       <= '0;
                        r_base      <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Mean and difference tables.
    always_ff @(posedge i_clk) begin
        if (w_pop && (i_q_op.kind == CMD_MEAN)) begin
            r_mean[i_q_op.index[POS_W-1:0]] <= i_q_op.value;
        end
        if (w_feature) begin
            r_diff[r_pos] <= w_diff;
        end
    end

    // Factor memory: write port.
    always_ff @(posedge i_clk) begin
        if (w_pop && (i_q_op.kind == CMD_FACTOR)) begin
            r_factor[ADDR_W'(i_q_op.index)] <= i_q_op.value;
        end
    end

    // Factor memory: registered read port, with the matching difference.
    always_ff @(posedge i_clk) begin
        r_fdata <= r_factor[w_raddr];
        r_dj    <= r_diff[r_j];
    end

    // Multiply-accumulate, absolute value and three-pass squaring.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(r_fdata) * r_dj;
        if (r_v2) begin
            r_sum <= r_sum + {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end else if (w_feature) begin
            r_sum <= '0;
        end
        if (r_state == ST_ABS) begin
            r_mag <= w_y[MAG_W-1] ? (~w_y + 1'b1) : w_y;
        end
        unique case (r_state)
            ST_SQ_LL: r_sq <= SQ_W'(w_lo * w_lo);
            ST_SQ_HL: r_sq <= r_sq + (SQ_W'(w_hi * w_lo) << (LO_W + 1));
            ST_SQ_HH: r_sq <= r_sq + (SQ_W'(w_hi * w_hi) << (2 * LO_W));
            default:  r_sq <= r_sq;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_dist <= w_acc_next;
            r_out_sat  <= w_sat_next;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_dist  = r_out_dist;
    assign o_res_sat   = r_out_sat;

    // The product pipeline is empty whenever a new operation may start.
    `MDS_ASSERT_IMP(a_idle_pipe_empty, i_clk, i_rst_n, r_state == ST_IDLE, !r_v1 && !r_v2)
    // The column counter never passes the current row.
    `MDS_ASSERT_IMP(a_col_in_row, i_clk, i_rst_n, r_state == ST_MAC, r_j <= r_pos)
    // Emitting a result clears the vector state.
    `MDS_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n,
        (r_state == ST_ACC) && w_last && w_out_free,
        (r_pos == '0) && (r_acc == '0) && r_out_valid)
    // A final step blocked by a full result register keeps its sum.
    `MDS_ASSERT_NEXT(a_blocked_holds, i_clk, i_rst_n,
        (r_state == ST_ACC) && w_last && !w_out_free,
        (r_state == ST_ACC) && $stable(r_acc))

endmodule

// ----- rtl/core/mahalanobis_distance_squared.sv -----
`timescale 1ns / 1ps
// Streaming squared Mahalanobis distance. Each input transaction is a mean
// write, a factor write (packed row-major lower-triangular inverse Cholesky
// factor) or the next Q16.16 feature; after feature NFEAT-1 one result gives
// the distance in unsigned Q47.16, saturated at 2^63-1, with a flag that is
// set when any term or the sum saturated. A four-entry queue sits between
// the input side and the compute engine, so the input keeps accepting while
// the engine works and while a result waits in the output register, until
// four operations are queued. Writes outside the tables and the unused
// command are dropped at the input and cost no engine time. The engine runs
// one operation at a time. Each feature at position p (from 0) goes through
// the single shared multiply-accumulate unit, which walks the p+1 factor
// entries of its row through a registered memory read, followed by a
// three-pass squarer and the saturating add. The last feature of a vector
// waits in the engine until the output register is free. Tables need no
// clearing and are valid once written.

module mahalanobis_distance_squared #(
    parameter int NFEAT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] index, [37:6] value, [39:38] zero
    input  logic [mds_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] cmd
    input  logic [mds_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [62:0] distance_sq, [63] zero
    output logic [mds_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] saturated
    output logic [0:0]                          m_axis_tuser
);
    import mds_pkg::*;

    logic              w_push;
    logic              w_full;
    logic              w_q_valid;
    logic              w_pop;
    t_op               w_push_op;
    t_op               w_q_op;
    logic [DIST_W-1:0] w_dist;
    logic              w_sat;

    // Input side: classify each transaction.
    mds_front #(
        .NFEAT (NFEAT)
    ) u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser),
        .i_index  (s_axis_tdata[INDEX_W-1:0]),
        .i_value  (s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    // Operation queue.
    mds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_pop)
    );

    // Compute engine and result register.
    mds_back #(
        .NFEAT (NFEAT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_op),
        .o_q_pop     (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_dist  (w_dist),
        .o_res_sat   (w_sat)
    );

    assign m_axis_tdata = {1'b0, w_dist};
    assign m_axis_tuser = w_sat;

endmodule
